// ===== rtl/ahd_pkg.sv =====
// Shared constants, types and register map for the attack-hold-decay envelope generator.
`timescale 1ns / 1ps
`default_nettype none

package ahd_pkg;

    // Fixed-point format of the level and width of the hold counter.
    localparam int FRAC_BITS = 24;
    localparam int HOLD_BITS = 24;

    // Derived field widths.
    localparam int LEVEL_W  = FRAC_BITS + 1;
    localparam int COEFF_W  = FRAC_BITS + 1;
    localparam int TARGET_W = FRAC_BITS + 4;
    localparam int HCOUNT_W = HOLD_BITS + 1;

    // Datapath widths of the one-pole step.
    localparam int MAG_W  = FRAC_BITS + 4;
    localparam int PROD_W = COEFF_W + MAG_W;
    localparam int INC_W  = PROD_W - FRAC_BITS;
    localparam int SUM_W  = INC_W + 2;

    // Configuration port geometry.
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Full scale, decay floor magnitude and the rounding addend for a ceiling shift.
    localparam logic [LEVEL_W-1:0] LEVEL_ONE   = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [LEVEL_W-1:0] DECAY_FLOOR =
        LEVEL_W'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [PROD_W-1:0]  ROUND_ADD   = PROD_W'((64'd1 << FRAC_BITS) - 64'd1);

    // Register reset values.
    localparam logic [COEFF_W-1:0]   ATTACK_COEFF_RST  = COEFF_W'(3226);
    localparam logic [TARGET_W-1:0]  ATTACK_TARGET_RST = TARGET_W'(16944988);
    localparam logic [HOLD_BITS-1:0] HOLD_LENGTH_RST   = '0;
    localparam logic [COEFF_W-1:0]   DECAY_COEFF_RST   = COEFF_W'(3495);

    // Envelope segments.
    typedef enum logic [1:0] {
        SEG_IDLE   = 2'd0,
        SEG_ATTACK = 2'd1,
        SEG_HOLD   = 2'd2,
        SEG_DECAY  = 2'd3
    } t_segment;

    // Register indexes on the configuration port.
    typedef enum logic [1:0] {
        REG_ATTACK_COEFF  = 2'd0,
        REG_ATTACK_TARGET = 2'd1,
        REG_HOLD_LENGTH   = 2'd2,
        REG_DECAY_COEFF   = 2'd3
    } t_reg_index;

    // Configuration register set.
    typedef struct packed {
        logic [COEFF_W-1:0]   attack_coeff;
        logic [TARGET_W-1:0]  attack_target;
        logic [HOLD_BITS-1:0] hold_length;
        logic [COEFF_W-1:0]   decay_coeff;
    } t_cfg;

    // Envelope state carried from tick to tick.
    typedef struct packed {
        logic [LEVEL_W-1:0]  level;
        logic [HCOUNT_W-1:0] hold_count;
        t_segment            segment;
    } t_env_state;

endpackage

`default_nettype wire

// ===== rtl/ahd_envelope_generator.sv =====
// Top level of the attack-hold-decay envelope generator: handshake, state and result registers.
`timescale 1ns / 1ps
`default_nettype none

// Attack-hold-decay envelope generator, one input beat per sample tick.
// Input channel (i_valid / o_stall) carries i_trigger and i_hard_restart; each
// accepted beat produces exactly one output beat (o_valid / i_stall) with the
// envelope level (unsigned Q1.24) and the segment after the step.
// Throughput: one beat per cycle while the receiver does not stall. The envelope
// recurrence (one 25x28 multiply, an add and a clip) closes combinationally around
// the state registers. A beat is registered at the input, stepped into the output
// register, and taken from there by the receiver.
// When the receiver stalls, the output register holds its beat, the input
// register fills, and o_stall rises only when both are occupied.
// Reset (synchronous, active low) empties both registers, returns the envelope
// to idle with level zero and loads the default coefficients.
// Configuration goes through the APB-style port; write it only while no beat
// is in flight.
module ahd_envelope_generator (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic                        i_trigger,
    input  wire logic                        i_hard_restart,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [ahd_pkg::LEVEL_W-1:0]      o_level,
    output logic [1:0]                       o_segment,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ahd_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [ahd_pkg::DATA_W-1:0]  pwdata,
    output logic      [ahd_pkg::DATA_W-1:0]  prdata,
    output logic                             pready
);

    ahd_pkg::t_cfg               cfg;
    ahd_pkg::t_env_state         r_state;
    ahd_pkg::t_env_state         n_state;
    logic [ahd_pkg::LEVEL_W-1:0] n_level;
    logic                        r_in_valid;
    logic                        r_in_trigger;
    logic                        r_in_hard;
    logic                        r_out_valid;
    logic [ahd_pkg::LEVEL_W-1:0] r_out_level;
    ahd_pkg::t_segment           r_out_segment;
    logic                        out_free;
    logic                        advance;
    logic                        in_take;

    // Configuration registers.
    ahd_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Envelope step for the beat in the input register.
    ahd_step u_step (
        .i_cfg          (cfg),
        .i_state        (r_state),
        .i_trigger      (r_in_trigger),
        .i_hard_restart (r_in_hard),
        .o_state        (n_state),
        .o_level        (n_level)
    );

    // Handshake: the input register moves on when the output register is free.
    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign in_take  = i_valid && !o_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_trigger <= i_trigger;
            r_in_hard    <= i_hard_restart;
        end
    end

    // Envelope state, updated once per stepped beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.level      <= '0;
            r_state.hold_count <= '0;
            r_state.segment    <= ahd_pkg::SEG_IDLE;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_level   <= n_level;
            r_out_segment <= n_state.segment;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_level   = r_out_level;
    assign o_segment = r_out_segment;

    // The level never leaves the range zero to full scale.
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_level <= ahd_pkg::LEVEL_ONE))
        else $error("envelope level above full scale");

    // An idle result always reports zero level.
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_segment == ahd_pkg::SEG_IDLE)) |-> (o_level == '0))
        else $error("idle result with nonzero level");

    // A hold result always reports full scale.
    a_hold_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_segment == ahd_pkg::SEG_HOLD)) |-> (o_level == ahd_pkg::LEVEL_ONE))
        else $error("hold result below full scale");

    // The envelope state moves only when a beat is stepped.
    a_state_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state))
        else $error("envelope state changed without a beat");

endmodule

`default_nettype wire

// ===== rtl/ahd_apb_regs.sv =====
// Configuration registers of the envelope generator behind an APB-style port.
`timescale 1ns / 1ps
`default_nettype none

module ahd_apb_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [ahd_pkg::ADDR_W-1:0] paddr,
    input  wire logic [ahd_pkg::DATA_W-1:0] pwdata,
    output logic      [ahd_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output ahd_pkg::t_cfg                   o_cfg
);

    ahd_pkg::t_cfg      r_cfg;
    ahd_pkg::t_reg_index reg_sel;
    logic               wr_en;

    // Word-aligned decode: the register index sits above the byte offset.
    assign reg_sel = ahd_pkg::t_reg_index'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Register writes on the access cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attack_coeff  <= ahd_pkg::ATTACK_COEFF_RST;
            r_cfg.attack_target <= ahd_pkg::ATTACK_TARGET_RST;
            r_cfg.hold_length   <= ahd_pkg::HOLD_LENGTH_RST;
            r_cfg.decay_coeff   <= ahd_pkg::DECAY_COEFF_RST;
        end else if (wr_en) begin
            case (reg_sel)
                ahd_pkg::REG_ATTACK_COEFF: begin
                    r_cfg.attack_coeff <= pwdata[ahd_pkg::COEFF_W-1:0];
                end
                ahd_pkg::REG_ATTACK_TARGET: begin
                    r_cfg.attack_target <= pwdata[ahd_pkg::TARGET_W-1:0];
                end
                ahd_pkg::REG_HOLD_LENGTH: begin
                    r_cfg.hold_length <= pwdata[ahd_pkg::HOLD_BITS-1:0];
                end
                ahd_pkg::REG_DECAY_COEFF: begin
                    r_cfg.decay_coeff <= pwdata[ahd_pkg::COEFF_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Read data mux.
    always_comb begin
        case (reg_sel)
            ahd_pkg::REG_ATTACK_COEFF:  prdata = ahd_pkg::DATA_W'(r_cfg.attack_coeff);
            ahd_pkg::REG_ATTACK_TARGET: prdata = ahd_pkg::DATA_W'(r_cfg.attack_target);
            ahd_pkg::REG_HOLD_LENGTH:   prdata = ahd_pkg::DATA_W'(r_cfg.hold_length);
            ahd_pkg::REG_DECAY_COEFF:   prdata = ahd_pkg::DATA_W'(r_cfg.decay_coeff);
            default:                    prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/ahd_step.sv =====
// Next-state logic of the envelope: trigger handling, one-pole step, clipping and hold count.
`timescale 1ns / 1ps
`default_nettype none

module ahd_step (
    input  wire ahd_pkg::t_cfg               i_cfg,
    input  wire ahd_pkg::t_env_state         i_state,
    input  wire logic                        i_trigger,
    input  wire logic                        i_hard_restart,
    output ahd_pkg::t_env_state              o_state,
    output logic [ahd_pkg::LEVEL_W-1:0]      o_level
);

    ahd_pkg::t_segment                   seg_eff;
    logic [ahd_pkg::LEVEL_W-1:0]         lvl_eff;
    logic [ahd_pkg::HCOUNT_W-1:0]        hc_eff;
    logic [ahd_pkg::HCOUNT_W-1:0]        hc_inc;
    logic [ahd_pkg::MAG_W-1:0]           lvl_wide;
    logic                                target_below;
    logic                                step_neg;
    logic [ahd_pkg::MAG_W-1:0]           step_mag;
    logic [ahd_pkg::COEFF_W-1:0]         step_coeff;
    logic [ahd_pkg::PROD_W-1:0]          step_prod;
    logic [ahd_pkg::INC_W-1:0]           step_inc;
    logic signed [ahd_pkg::SUM_W-1:0]    lvl_s;
    logic signed [ahd_pkg::SUM_W-1:0]    inc_s;
    logic signed [ahd_pkg::SUM_W-1:0]    sum_s;
    logic signed [ahd_pkg::SUM_W-1:0]    one_s;

    // A trigger restarts attack before the tick; a hard restart also clears the level.
    always_comb begin
        seg_eff = i_trigger ? ahd_pkg::SEG_ATTACK : i_state.segment;
        lvl_eff = (i_trigger && i_hard_restart) ? '0 : i_state.level;
        hc_eff  = i_trigger ? '0 : i_state.hold_count;
    end

    // Magnitude and direction of the distance to the segment's asymptote.
    always_comb begin
        lvl_wide     = ahd_pkg::MAG_W'(lvl_eff);
        target_below = i_cfg.attack_target < lvl_wide;
        if (seg_eff == ahd_pkg::SEG_DECAY) begin
            step_neg   = 1'b1;
            step_mag   = lvl_wide + ahd_pkg::MAG_W'(ahd_pkg::DECAY_FLOOR);
            step_coeff = i_cfg.decay_coeff;
        end else begin
            step_neg   = target_below;
            step_mag   = target_below ? (lvl_wide - i_cfg.attack_target)
                                      : (i_cfg.attack_target - lvl_wide);
            step_coeff = i_cfg.attack_coeff;
        end
    end

    // One multiply, increment magnitude rounded up, then the signed update.
    always_comb begin
        step_prod = ahd_pkg::PROD_W'(step_coeff) * ahd_pkg::PROD_W'(step_mag);
        step_inc  = ahd_pkg::INC_W'((step_prod + ahd_pkg::ROUND_ADD) >> ahd_pkg::FRAC_BITS);
        lvl_s     = signed'(ahd_pkg::SUM_W'(lvl_eff));
        inc_s     = signed'(ahd_pkg::SUM_W'(step_inc));
        one_s     = signed'(ahd_pkg::SUM_W'(ahd_pkg::LEVEL_ONE));
        sum_s     = step_neg ? (lvl_s - inc_s) : (lvl_s + inc_s);
        hc_inc    = hc_eff + ahd_pkg::HCOUNT_W'(1);
    end

    // Segment behavior and clipping.
    always_comb begin
        o_state.level      = lvl_eff;
        o_state.hold_count = hc_eff;
        o_state.segment    = seg_eff;
        o_level            = '0;
        case (seg_eff)
            ahd_pkg::SEG_ATTACK: begin
                if (sum_s < 0) begin
                    o_state.level = '0;
                end else if (sum_s > one_s) begin
                    o_state.level      = ahd_pkg::LEVEL_ONE;
                    o_state.hold_count = '0;
                    o_state.segment    = ahd_pkg::SEG_HOLD;
                end else begin
                    o_state.level = ahd_pkg::LEVEL_W'(sum_s);
                end
                o_level = o_state.level;
            end
            ahd_pkg::SEG_HOLD: begin
                o_state.hold_count = hc_inc;
                o_level            = ahd_pkg::LEVEL_ONE;
                if (hc_inc > ahd_pkg::HCOUNT_W'(i_cfg.hold_length)) begin
                    o_state.level   = ahd_pkg::LEVEL_ONE;
                    o_state.segment = ahd_pkg::SEG_DECAY;
                end
            end
            ahd_pkg::SEG_DECAY: begin
                if (sum_s < 0) begin
                    o_state.level   = '0;
                    o_state.segment = ahd_pkg::SEG_IDLE;
                end else begin
                    o_state.level = ahd_pkg::LEVEL_W'(sum_s);
                end
                o_level = o_state.level;
            end
            default: begin
                o_level = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sim/ahd_envelope_checker.sv =====
// Checker for the envelope generator: tracks register writes, predicts each output beat and compares.
`timescale 1ns / 1ps

module ahd_envelope_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic                        i_trigger,
    input  logic                        i_hard_restart,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic [ahd_pkg::LEVEL_W-1:0] i_level,
    input  logic [1:0]                  i_segment,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic                        i_pready,
    input  logic [ahd_pkg::ADDR_W-1:0]  i_paddr,
    input  logic [ahd_pkg::DATA_W-1:0]  i_pwdata,
    output int                          o_fail_count,
    output int                          o_pending
);

    // Full scale and decay floor as wide signed numbers for the step arithmetic.
    localparam longint UNITY_L = longint'(1) << ahd_pkg::FRAC_BITS;
    localparam longint FLOOR_L = longint'(ahd_pkg::DECAY_FLOOR);

    // One predicted output beat.
    typedef struct packed {
        logic [ahd_pkg::LEVEL_W-1:0] level;
        ahd_pkg::t_segment           segment;
    } t_envelope_beat;

    ahd_pkg::t_cfg       shadow_cfg;
    ahd_pkg::t_env_state shadow_env;
    t_envelope_beat      predicted_beats[$];
    t_envelope_beat      want;
    t_envelope_beat      fresh;
    int                  mismatch_count = 0;

    // One-pole increment: the sign follows the distance, the magnitude is rounded up.
    function automatic longint pole_increment(input longint coeff, input longint distance);
        longint magnitude;
        longint inc;
        magnitude = (distance < 0) ? -distance : distance;
        inc = (coeff * magnitude + UNITY_L - 1) >>> ahd_pkg::FRAC_BITS;
        return (distance < 0) ? -inc : inc;
    endfunction

    // Advance the shadow envelope by one tick and produce the beat it should emit.
    task automatic advance_envelope(input logic trig, input logic hard,
                                    output t_envelope_beat beat);
        longint next_level;
        beat.level = '0;
        if (trig) begin
            shadow_env.segment    = ahd_pkg::SEG_ATTACK;
            shadow_env.hold_count = '0;
            if (hard) begin
                shadow_env.level = '0;
            end
        end
        case (shadow_env.segment)
            ahd_pkg::SEG_ATTACK: begin
                next_level = longint'(shadow_env.level)
                    + pole_increment(longint'(shadow_cfg.attack_coeff),
                                     longint'(shadow_cfg.attack_target)
                                     - longint'(shadow_env.level));
                if (next_level < 0) begin
                    next_level = 0;
                end
                if (next_level > UNITY_L) begin
                    next_level            = UNITY_L;
                    shadow_env.hold_count = '0;
                    shadow_env.segment    = ahd_pkg::SEG_HOLD;
                end
                shadow_env.level = ahd_pkg::LEVEL_W'(next_level);
                beat.level       = shadow_env.level;
            end
            ahd_pkg::SEG_HOLD: begin
                shadow_env.hold_count = shadow_env.hold_count + 1'b1;
                beat.level            = ahd_pkg::LEVEL_ONE;
                if (shadow_env.hold_count > {1'b0, shadow_cfg.hold_length}) begin
                    shadow_env.level   = ahd_pkg::LEVEL_ONE;
                    shadow_env.segment = ahd_pkg::SEG_DECAY;
                end
            end
            ahd_pkg::SEG_DECAY: begin
                next_level = longint'(shadow_env.level)
                    + pole_increment(longint'(shadow_cfg.decay_coeff),
                                     -FLOOR_L - longint'(shadow_env.level));
                if (next_level < 0) begin
                    next_level         = 0;
                    shadow_env.segment = ahd_pkg::SEG_IDLE;
                end
                shadow_env.level = ahd_pkg::LEVEL_W'(next_level);
                beat.level       = shadow_env.level;
            end
            default: begin
                beat.level = '0;
            end
        endcase
        beat.segment = shadow_env.segment;
    endtask

    // Watch both channels and the register port at every rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_cfg.attack_coeff  = ahd_pkg::ATTACK_COEFF_RST;
            shadow_cfg.attack_target = ahd_pkg::ATTACK_TARGET_RST;
            shadow_cfg.hold_length   = ahd_pkg::HOLD_LENGTH_RST;
            shadow_cfg.decay_coeff   = ahd_pkg::DECAY_COEFF_RST;
            shadow_env.level         = '0;
            shadow_env.hold_count    = '0;
            shadow_env.segment       = ahd_pkg::SEG_IDLE;
            predicted_beats.delete();
        end else begin
            // Compare an output beat with the oldest prediction.
            if (i_out_valid && !i_out_stall) begin
                if (predicted_beats.size() == 0) begin
                    $display("%0t: output beat with nothing expected, level %0d segment %0d",
                             $time, i_level, i_segment);
                    mismatch_count++;
                end else begin
                    want = predicted_beats.pop_front();
                    if (i_level !== want.level) begin
                        $display("%0t: level mismatch, expected %0d, got %0d",
                                 $time, want.level, i_level);
                        mismatch_count++;
                    end
                    if (i_segment !== want.segment) begin
                        $display("%0t: segment mismatch, expected %0d, got %0d",
                                 $time, want.segment, i_segment);
                        mismatch_count++;
                    end
                end
            end

            // Every accepted input beat yields exactly one output beat.
            if (i_in_valid && !i_in_stall) begin
                advance_envelope(i_trigger, i_hard_restart, fresh);
                predicted_beats.push_back(fresh);
            end

            // Mirror register writes.
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (ahd_pkg::t_reg_index'(i_paddr[3:2]))
                    ahd_pkg::REG_ATTACK_COEFF: begin
                        shadow_cfg.attack_coeff = ahd_pkg::COEFF_W'(i_pwdata);
                    end
                    ahd_pkg::REG_ATTACK_TARGET: begin
                        shadow_cfg.attack_target = ahd_pkg::TARGET_W'(i_pwdata);
                    end
                    ahd_pkg::REG_HOLD_LENGTH: begin
                        shadow_cfg.hold_length = ahd_pkg::HOLD_BITS'(i_pwdata);
                    end
                    ahd_pkg::REG_DECAY_COEFF: begin
                        shadow_cfg.decay_coeff = ahd_pkg::COEFF_W'(i_pwdata);
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_fail_count <= mismatch_count;
        o_pending    <= predicted_beats.size();
    end

endmodule

// ===== sim/ahd_envelope_generator_test.sv =====
// Testbench top for the envelope generator: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module ahd_envelope_generator_test;

    // Register value limits.
    localparam int UNITY      = 1 << ahd_pkg::FRAC_BITS;
    localparam int COEFF_MAX  = (1 << ahd_pkg::COEFF_W) - 1;
    localparam int TARGET_MAX = (1 << ahd_pkg::TARGET_W) - 1;
    localparam int HOLD_MAX   = (1 << ahd_pkg::HOLD_BITS) - 1;

    // Run length.
    localparam int RAND_PHASES     = 11;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int CYCLE_LIMIT     = 200000;

    // Receiver stall modes.
    localparam int STALL_NONE  = 0;
    localparam int STALL_LIGHT = 1;
    localparam int STALL_HEAVY = 2;

    logic                         i_clk          = 1'b0;
    logic                         i_rst_n        = 1'b0;
    logic                         i_valid        = 1'b0;
    logic                         i_trigger      = 1'b0;
    logic                         i_hard_restart = 1'b0;
    logic                         i_stall        = 1'b0;
    logic                         psel           = 1'b0;
    logic                         penable        = 1'b0;
    logic                         pwrite         = 1'b0;
    logic [ahd_pkg::ADDR_W-1:0]   paddr          = '0;
    logic [ahd_pkg::DATA_W-1:0]   pwdata         = '0;
    logic                         o_stall;
    logic                         o_valid;
    logic [ahd_pkg::LEVEL_W-1:0]  o_level;
    logic [1:0]                   o_segment;
    logic [ahd_pkg::DATA_W-1:0]   prdata;
    logic                         pready;

    int fail_count;
    int pending_beats;
    int cycle_count = 0;
    int stall_mode  = STALL_NONE;
    int mode_left   = 100;

    ahd_envelope_generator DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_trigger      (i_trigger),
        .i_hard_restart (i_hard_restart),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_level        (o_level),
        .o_segment      (o_segment),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    ahd_envelope_checker envelope_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_trigger      (i_trigger),
        .i_hard_restart (i_hard_restart),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_level        (o_level),
        .i_segment      (o_segment),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending_beats)
    );

    // 50 MHz clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Cycle counter that ends a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver stalls: switch between no, light and heavy stalling every so often.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(STALL_NONE, STALL_HEAVY);
                mode_left  <= $urandom_range(30, 400);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: i_stall <= ($urandom_range(0, 9) < 7);
                default:     i_stall <= 1'b0;
            endcase
        end
    end

    // Register write: setup cycle, then access cycle until pready.
    task automatic write_reg(input ahd_pkg::t_reg_index idx,
                             input logic [ahd_pkg::DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ahd_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    // Load all four envelope registers back to back.
    task automatic program_envelope(input logic [ahd_pkg::DATA_W-1:0] attack_coeff,
                                    input logic [ahd_pkg::DATA_W-1:0] attack_target,
                                    input logic [ahd_pkg::DATA_W-1:0] hold_length,
                                    input logic [ahd_pkg::DATA_W-1:0] decay_coeff);
        write_reg(ahd_pkg::REG_ATTACK_COEFF, attack_coeff);
        write_reg(ahd_pkg::REG_ATTACK_TARGET, attack_target);
        write_reg(ahd_pkg::REG_HOLD_LENGTH, hold_length);
        write_reg(ahd_pkg::REG_DECAY_COEFF, decay_coeff);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Present one tick beat and hold it until it is accepted.
    task automatic send_tick(input logic trig, input logic hard);
        i_valid        <= 1'b1;
        i_trigger      <= trig;
        i_hard_restart <= hard;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Sender gap of the given number of cycles.
    task automatic hold_off(input int cycles);
        if (cycles > 0) begin
            i_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Stop sending and wait until every predicted beat has come out.
    task automatic drain_envelope();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_beats != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Coefficient choice: mostly moderate, sometimes instant or beyond full scale.
    function automatic logic [ahd_pkg::DATA_W-1:0] pick_coeff();
        case ($urandom_range(0, 9))
            0:       return UNITY;
            1:       return $urandom_range(UNITY + 1, COEFF_MAX);
            default: return (UNITY >> $urandom_range(1, 7)) + $urandom_range(0, 255);
        endcase
    endfunction

    // Random ticks in bursts; triggers are sparse so that segments run their course.
    task automatic run_ticks(input int count, input int trig_span);
        int burst_left;
        burst_left = $urandom_range(1, 24);
        repeat (count) begin
            send_tick($urandom_range(0, trig_span) == 0, 1'($urandom_range(0, 1)));
            burst_left--;
            if (burst_left == 0) begin
                if ($urandom_range(0, 39) == 0) begin
                    drain_envelope();
                end else begin
                    hold_off($urandom_range(0, 8));
                end
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                         : $urandom_range(1, 24);
            end
        end
    endtask

    // Main stimulus.
    initial begin
        int phase;
        int trig_span;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset coefficients: trigger, hard restart alone, hard restart with trigger.
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);
        drain_envelope();

        // Instant attack and decay with the highest target and a short hold.
        program_envelope(UNITY, TARGET_MAX, 2, UNITY);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        repeat (4) send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        drain_envelope();

        // Coefficients beyond full scale overshoot and get clipped.
        program_envelope(COEFF_MAX, UNITY + 1, 0, COEFF_MAX);
        send_tick(1'b1, 1'b1);
        repeat (3) send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        drain_envelope();

        // Target below full scale: attack settles without ever reaching hold.
        program_envelope(UNITY / 4, UNITY / 2, 0, 0);
        send_tick(1'b1, 1'b1);
        repeat (2) send_tick(1'b0, 1'b0);
        drain_envelope();

        // Zero attack coefficient leaves the level where it is.
        program_envelope(0, 0, 0, UNITY / 8);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        drain_envelope();

        // Target of zero pulls the level down toward zero.
        program_envelope(UNITY / 2, 0, 0, UNITY / 8);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        drain_envelope();

        // Zero decay coefficient parks the envelope in decay at full scale.
        program_envelope(UNITY, TARGET_MAX, 1, 0);
        send_tick(1'b1, 1'b0);
        repeat (3) send_tick(1'b0, 1'b0);
        drain_envelope();

        // Random phases, each with its own register setting.
        for (phase = 0; phase < RAND_PHASES; phase++) begin
            case (phase)
                0: program_envelope(1, UNITY + 1, 0, 1);
                1: program_envelope(COEFF_MAX, TARGET_MAX, HOLD_MAX, COEFF_MAX);
                default: begin
                    program_envelope(pick_coeff(),
                                     ($urandom_range(0, 3) == 0)
                                         ? $urandom_range(UNITY + 1, TARGET_MAX)
                                         : $urandom_range(UNITY + UNITY / 16, 2 * UNITY),
                                     ($urandom_range(0, 7) == 0)
                                         ? $urandom_range(0, HOLD_MAX)
                                         : $urandom_range(0, 12),
                                     pick_coeff());
                end
            endcase
            case ($urandom_range(0, 2))
                0:       trig_span = 3;
                1:       trig_span = 30;
                default: trig_span = 120;
            endcase
            run_ticks(ITEMS_PER_PHASE, trig_span);
            drain_envelope();
        end

        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ahd_pkg.sv
rtl/ahd_apb_regs.sv
rtl/ahd_step.sv
rtl/ahd_envelope_generator.sv
sim/ahd_envelope_checker.sv
sim/ahd_envelope_generator_test.sv
